// ===== hw/rtl/twva_pkg.sv =====
// Shared constants, types and state codes of the time window vector average block.
package twva_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int TIME_W         = 64;
  localparam int AXIS_W         = 32;
  localparam int CNT_OUT_W      = 9;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  // One second in nanoseconds.
  localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 32'd1000000000;

  // Register index taken from paddr above the byte offset.
  localparam logic [0:0] REG_WINDOW = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FULL_RD,
    ST_FULL_SUB,
    ST_WRITE,
    ST_EVICT_RD,
    ST_EVICT_CHK,
    ST_DIV_START,
    ST_DIV_WAIT
  } twva_state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic drop;
    logic div_start;
  } twva_lane_ctl_t;

endpackage

// ===== hw/rtl/twva_stream_if.sv =====
// Valid/ready channel interfaces for samples and window means.
interface twva_in_if;
  logic                              valid;
  logic                              ready;
  logic        [twva_pkg::TIME_W-1:0] sample_time_ns;
  logic signed [twva_pkg::AXIS_W-1:0] accel_x;
  logic signed [twva_pkg::AXIS_W-1:0] accel_y;
  logic signed [twva_pkg::AXIS_W-1:0] accel_z;

  modport source (output valid, sample_time_ns, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, sample_time_ns, accel_x, accel_y, accel_z, output ready);
endinterface

interface twva_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [twva_pkg::AXIS_W-1:0]    mean_x;
  logic signed [twva_pkg::AXIS_W-1:0]    mean_y;
  logic signed [twva_pkg::AXIS_W-1:0]    mean_z;
  logic        [twva_pkg::CNT_OUT_W-1:0] samples_in_window;

  modport source (output valid, mean_x, mean_y, mean_z, samples_in_window, input ready);
  modport sink (input valid, mean_x, mean_y, mean_z, samples_in_window, output ready);
endinterface

// ===== hw/rtl/twva_cfg.sv =====
// APB register file holding the window length.
module twva_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [twva_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [twva_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [twva_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [twva_pkg::CFG_DATA_W-1:0]  window_len
);

  logic [twva_pkg::CFG_DATA_W-1:0] window_r;
  logic                            hit_window;

  assign pready     = 1'b1;
  assign hit_window = (paddr[twva_pkg::CFG_ADDR_W-1:2] == twva_pkg::REG_WINDOW);
  assign window_len = window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= twva_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && hit_window) begin
      window_r <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (hit_window) begin
      prdata = window_r;
    end
  end

endmodule

// ===== hw/rtl/twva_lane.sv =====
// One axis lane: sample ring, running sum and serial signed divider.
module twva_lane #(
  parameter int RING_DEPTH = twva_pkg::RING_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  twva_pkg::twva_lane_ctl_t              ctl,
  input  logic [$clog2(RING_DEPTH)-1:0]         addr,
  input  logic signed [twva_pkg::AXIS_W-1:0]    wr_data,
  input  logic [$clog2(RING_DEPTH+1)-1:0]       cnt,
  output logic signed [twva_pkg::AXIS_W-1:0]    quot,
  output logic                                  done
);

  localparam int AW     = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH+1);
  localparam int SUM_W  = twva_pkg::AXIS_W + AW;
  localparam int STEP_W = $clog2(SUM_W+1);
  localparam int XW     = SUM_W - twva_pkg::AXIS_W;

  logic signed [twva_pkg::AXIS_W-1:0] mem [RING_DEPTH];
  logic signed [twva_pkg::AXIS_W-1:0] rd_data_r;
  logic signed [SUM_W-1:0]            sum_r;
  logic        [SUM_W-1:0]            wr_ext;
  logic        [SUM_W-1:0]            rd_ext;

  logic [SUM_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  den_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;

  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W:0]    diff;
  logic [CNT_W-1:0]  rem_nxt;
  logic [SUM_W-1:0]  dvd_nxt;
  logic [twva_pkg::AXIS_W-1:0] q_mag;

  assign wr_ext = {{XW{wr_data[twva_pkg::AXIS_W-1]}}, wr_data};
  assign rd_ext = {{XW{rd_data_r[twva_pkg::AXIS_W-1]}}, rd_data_r};

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // Restoring division, one quotient bit per cycle.
  assign trial   = {rem_r, dvd_r[SUM_W-1]};
  assign fits    = (trial >= {1'b0, den_r});
  assign diff    = trial - {1'b0, den_r};
  assign rem_nxt = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  assign dvd_nxt = {dvd_r[SUM_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (ctl.wr_en) begin
        sum_r <= sum_r + wr_ext;
      end else if (ctl.drop) begin
        sum_r <= sum_r - rd_ext;
      end
      if (ctl.div_start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      neg_r <= sum_r[SUM_W-1];
      dvd_r <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
      rem_r <= '0;
      den_r <= cnt;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Magnitude never exceeds 2^31, so the low word negates cleanly.
  assign q_mag = dvd_r[twva_pkg::AXIS_W-1:0];
  assign quot  = neg_r ? -q_mag : q_mag;
  assign done  = done_r;

endmodule

// ===== hw/rtl/twva_ctrl.sv =====
// Sequencer: ring pointers, timestamp ring, window cutoff and lane control.
module twva_ctrl #(
  parameter int RING_DEPTH = twva_pkg::RING_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [twva_pkg::TIME_W-1:0]         in_time,
  input  logic signed [twva_pkg::AXIS_W-1:0]  in_x,
  input  logic signed [twva_pkg::AXIS_W-1:0]  in_y,
  input  logic signed [twva_pkg::AXIS_W-1:0]  in_z,
  input  logic [twva_pkg::CFG_DATA_W-1:0]     window_len,
  output twva_pkg::twva_lane_ctl_t            lane_ctl,
  output logic [$clog2(RING_DEPTH)-1:0]       lane_addr,
  output logic signed [twva_pkg::AXIS_W-1:0]  wr_x,
  output logic signed [twva_pkg::AXIS_W-1:0]  wr_y,
  output logic signed [twva_pkg::AXIS_W-1:0]  wr_z,
  output logic [$clog2(RING_DEPTH+1)-1:0]     held,
  input  logic                                lanes_done,
  input  logic                                out_free,
  output logic                                out_load
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH+1);

  twva_pkg::twva_state_t state_r, state_nxt;

  logic [AW-1:0]               oldest_r;
  logic [CNT_W-1:0]            held_r;
  logic [twva_pkg::TIME_W-1:0] t_r;
  logic [twva_pkg::TIME_W-1:0] cutoff_r;
  logic                        young_r;
  logic signed [twva_pkg::AXIS_W-1:0] x_r, y_r, z_r;
  logic [twva_pkg::TIME_W-1:0] time_mem [RING_DEPTH];
  logic [twva_pkg::TIME_W-1:0] time_rd_r;

  logic                        accept;
  logic                        full;
  logic                        may_evict;
  logic                        evict_hit;
  logic [AW:0]                 slot_sum;
  logic [AW-1:0]               wr_slot;
  logic [AW-1:0]               oldest_inc;
  logic [twva_pkg::TIME_W-1:0] window64;

  assign accept     = in_valid && in_ready;
  assign full       = (held_r == CNT_W'(RING_DEPTH));
  assign may_evict  = (held_r > CNT_W'(1)) && !young_r;
  assign evict_hit  = (time_rd_r < cutoff_r);
  assign slot_sum   = {1'b0, oldest_r} + (AW+1)'(held_r);
  assign wr_slot    = (slot_sum >= (AW+1)'(RING_DEPTH)) ?
                      AW'(slot_sum - (AW+1)'(RING_DEPTH)) : slot_sum[AW-1:0];
  assign oldest_inc = (oldest_r == AW'(RING_DEPTH-1)) ? '0 : oldest_r + 1'b1;
  assign window64   = {{(twva_pkg::TIME_W-twva_pkg::CFG_DATA_W){1'b0}}, window_len};

  assign lane_addr = (state_r == twva_pkg::ST_WRITE) ? wr_slot : oldest_r;
  assign wr_x      = x_r;
  assign wr_y      = y_r;
  assign wr_z      = z_r;
  assign held      = held_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      twva_pkg::ST_IDLE: begin
        if (accept) state_nxt = full ? twva_pkg::ST_FULL_RD : twva_pkg::ST_WRITE;
      end
      twva_pkg::ST_FULL_RD:   state_nxt = twva_pkg::ST_FULL_SUB;
      twva_pkg::ST_FULL_SUB:  state_nxt = twva_pkg::ST_WRITE;
      twva_pkg::ST_WRITE:     state_nxt = twva_pkg::ST_EVICT_RD;
      twva_pkg::ST_EVICT_RD: begin
        state_nxt = may_evict ? twva_pkg::ST_EVICT_CHK : twva_pkg::ST_DIV_START;
      end
      twva_pkg::ST_EVICT_CHK: begin
        state_nxt = evict_hit ? twva_pkg::ST_EVICT_RD : twva_pkg::ST_DIV_START;
      end
      twva_pkg::ST_DIV_START: state_nxt = twva_pkg::ST_DIV_WAIT;
      twva_pkg::ST_DIV_WAIT: begin
        if (lanes_done && out_free) state_nxt = twva_pkg::ST_IDLE;
      end
      default: state_nxt = twva_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    lane_ctl = '0;
    out_load = 1'b0;
    case (state_r)
      twva_pkg::ST_IDLE:      in_ready = 1'b1;
      twva_pkg::ST_FULL_RD:   lane_ctl.rd_en = 1'b1;
      twva_pkg::ST_FULL_SUB:  lane_ctl.drop = 1'b1;
      twva_pkg::ST_WRITE:     lane_ctl.wr_en = 1'b1;
      twva_pkg::ST_EVICT_RD:  lane_ctl.rd_en = may_evict;
      twva_pkg::ST_EVICT_CHK: lane_ctl.drop = evict_hit;
      twva_pkg::ST_DIV_START: lane_ctl.div_start = 1'b1;
      twva_pkg::ST_DIV_WAIT:  out_load = lanes_done && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= twva_pkg::ST_IDLE;
      oldest_r <= '0;
      held_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (lane_ctl.drop) begin
        oldest_r <= oldest_inc;
        held_r   <= held_r - 1'b1;
      end else if (lane_ctl.wr_en) begin
        held_r <= held_r + 1'b1;
      end
    end
  end

  // Hold the sample and its cutoff for the rest of the transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      t_r      <= in_time;
      x_r      <= in_x;
      y_r      <= in_y;
      z_r      <= in_z;
      cutoff_r <= in_time - window64;
      young_r  <= (in_time < window64);
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ctl.wr_en) begin
      time_mem[lane_addr] <= t_r;
    end
    if (lane_ctl.rd_en) begin
      time_rd_r <= time_mem[lane_addr];
    end
  end

endmodule

// ===== hw/rtl/twva_merge.sv =====
// Merge stage: gathers the lane quotients and count into the result register.
module twva_merge #(
  parameter int RING_DEPTH = twva_pkg::RING_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  logic signed [twva_pkg::AXIS_W-1:0]     q_x,
  input  logic signed [twva_pkg::AXIS_W-1:0]     q_y,
  input  logic signed [twva_pkg::AXIS_W-1:0]     q_z,
  input  logic [$clog2(RING_DEPTH+1)-1:0]        cnt,
  output logic                                   out_free,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [twva_pkg::AXIS_W-1:0]     mean_x,
  output logic signed [twva_pkg::AXIS_W-1:0]     mean_y,
  output logic signed [twva_pkg::AXIS_W-1:0]     mean_z,
  output logic [twva_pkg::CNT_OUT_W-1:0]         samples_in_window
);

  logic                                valid_r;
  logic signed [twva_pkg::AXIS_W-1:0]  mx_r, my_r, mz_r;
  logic [twva_pkg::CNT_OUT_W-1:0]      cnt_r;

  assign out_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mx_r  <= q_x;
      my_r  <= q_y;
      mz_r  <= q_z;
      cnt_r <= twva_pkg::CNT_OUT_W'(cnt);
    end
  end

  assign out_valid         = valid_r;
  assign mean_x            = mx_r;
  assign mean_y            = my_r;
  assign mean_z            = mz_r;
  assign samples_in_window = cnt_r;

endmodule

// ===== hw/rtl/time_window_vector_average_top.sv =====
// Top level of the time window vector average block.
//
//   channel  direction  handshake          payload
//   in_chan  sink       valid/ready        sample_time_ns, accel_x/y/z
//   out_chan source     valid/ready        mean_x/y/z, samples_in_window
//   apb      slave      psel/penable/pready window_length_ns at offset 0
//
// One sample at a time: after an accept the block drops the oldest entry when the ring is
// full, writes the sample, ages out expired entries with one read of the timestamp ring plus
// one compare each, then runs the serial divider in each axis lane (one quotient bit a cycle)
// and loads the result register once that register is free.
// Reset is synchronous; the rings are not cleared, while count, pointer, sums and state reset.
// A stalled result sits in the output register while the next sample is taken.
module time_window_vector_average_top #(
  parameter int RING_DEPTH = twva_pkg::RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  twva_in_if.sink                         in_chan,
  twva_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [twva_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [twva_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [twva_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH+1);

  logic [twva_pkg::CFG_DATA_W-1:0]    window_len;
  twva_pkg::twva_lane_ctl_t           lane_ctl;
  logic [AW-1:0]                      lane_addr;
  logic signed [twva_pkg::AXIS_W-1:0] wr_x, wr_y, wr_z;
  logic signed [twva_pkg::AXIS_W-1:0] q_x, q_y, q_z;
  logic                               done_x, done_y, done_z;
  logic [CNT_W-1:0]                   held;
  logic                               out_free;
  logic                               out_load;

  twva_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .window_len (window_len)
  );

  twva_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_time    (in_chan.sample_time_ns),
    .in_x       (in_chan.accel_x),
    .in_y       (in_chan.accel_y),
    .in_z       (in_chan.accel_z),
    .window_len (window_len),
    .lane_ctl   (lane_ctl),
    .lane_addr  (lane_addr),
    .wr_x       (wr_x),
    .wr_y       (wr_y),
    .wr_z       (wr_z),
    .held       (held),
    .lanes_done (done_x && done_y && done_z),
    .out_free   (out_free),
    .out_load   (out_load)
  );

  twva_lane #(.RING_DEPTH(RING_DEPTH)) u_lane_x (
    .clk (clk), .rst_n (rst_n), .ctl (lane_ctl), .addr (lane_addr),
    .wr_data (wr_x), .cnt (held), .quot (q_x), .done (done_x)
  );

  twva_lane #(.RING_DEPTH(RING_DEPTH)) u_lane_y (
    .clk (clk), .rst_n (rst_n), .ctl (lane_ctl), .addr (lane_addr),
    .wr_data (wr_y), .cnt (held), .quot (q_y), .done (done_y)
  );

  twva_lane #(.RING_DEPTH(RING_DEPTH)) u_lane_z (
    .clk (clk), .rst_n (rst_n), .ctl (lane_ctl), .addr (lane_addr),
    .wr_data (wr_z), .cnt (held), .quot (q_z), .done (done_z)
  );

  twva_merge #(.RING_DEPTH(RING_DEPTH)) u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (out_load),
    .q_x               (q_x),
    .q_y               (q_y),
    .q_z               (q_z),
    .cnt               (held),
    .out_free          (out_free),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .mean_x            (out_chan.mean_x),
    .mean_y            (out_chan.mean_y),
    .mean_z            (out_chan.mean_z),
    .samples_in_window (out_chan.samples_in_window)
  );

endmodule

// ===== hw/rtl/twva_checker.sv =====
// Port-level checks for the time window vector average block, bound to the top.
module twva_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [twva_pkg::AXIS_W-1:0]    mean_x,
  input logic [twva_pkg::CNT_OUT_W-1:0]        samples_in_window
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // No result may be left over from before reset.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Handle one transaction at a time: input closes right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // The divide is serial, so a result cannot rise right after an accept.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_valid) ##1 !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too soon after a transaction");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(mean_x) && $stable(samples_in_window))
    else $error("result changed while stalled");

endmodule

bind time_window_vector_average_top twva_checker u_twva_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .mean_x            (out_chan.mean_x),
  .samples_in_window (out_chan.samples_in_window)
);
